// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the k-mer counter RTL.
// Used by files that include this header; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define KOC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define KOC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define KOC_ASSERT(label, prop, msg)
`define KOC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: hw/rtl/kocnt_pkg.sv
// Package for the k-mer occurrence counter: field widths, register codes
// and the control group handed to every window cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kocnt_pkg;

  // Fixed field widths.
  localparam int unsigned SymW     = 8;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CountW   = 32;
  localparam int unsigned SkipW    = 3;
  localparam int unsigned PatW     = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_CHARS  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_OVERLAP_MODE   = 2'd2
  } cfg_reg_e;

  // Control shared by all cells of the window chain.
  typedef struct packed {
    logic step;   // a character transaction shifts the chain
    logic flush;  // the record ends with this character
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/kocnt_cell.sv
// One cell of the character window chain: holds one character of the
// record and compares it with its k-mer byte. Depends on kocnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kocnt_cell
  import kocnt_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic [SymW-1:0] sym_i,
  input  wire logic            vld_i,
  input  wire logic [PatW-1:0] pattern_i,
  input  wire logic [LenW-1:0] len_i,
  output logic      [SymW-1:0] sym_o,
  output logic                 vld_o,
  output logic                 hit_o
);

  localparam logic [LenW-1:0] Age = LenW'(CELL_IDX);

  logic [SymW-1:0] sym_q;
  logic            vld_q;
  logic [LenW-1:0] pat_off;
  logic [2:0]      pat_idx;
  logic [SymW-1:0] pat_byte;

  // This cell holds the character at this age; the k-mer byte it faces
  // counts back from the end of the pattern.
  assign pat_off  = len_i - Age - LenW'(1);
  assign pat_idx  = pat_off[2:0];
  assign pat_byte = pattern_i[pat_idx*SymW +: SymW];

  // The compare looks at the value entering the cell, so the new character
  // takes part in this cycle's match. Cells beyond the k-mer always agree.
  assign hit_o = (Age >= len_i) || (vld_i && (sym_i == pat_byte));

  // Character storage needs no reset; the valid bit masks it.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      sym_q <= sym_i;
    end
  end

  // Valid bit clears at reset and at the end of each record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.step) begin
      vld_q <= vld_i && !ctrl_i.flush;
    end
  end

  assign sym_o = sym_q;
  assign vld_o = vld_q;

endmodule

`default_nettype wire

// File: hw/rtl/kmer_occurrence_counter.sv
// Top level of the k-mer occurrence counter: configuration registers,
// window cell chain, match counter and output register.
// Depends on kocnt_pkg, kocnt_cell and assert_macros.svh.
//
// Usage:
//   Characters arrive on the input channel (in_valid_i / in_ready_o) with
//   symbol_i and last_symbol_i; one transaction carries one character.
//   The configured k-mer (pattern_chars, pattern_length, overlap_mode) is
//   written through cfg_we_i / cfg_index_i / cfg_wdata_i while idle.
//   For each record one result transaction (out_valid_o / out_ready_i)
//   carries match_count_o, the number of matches, saturating.
// Timing:
//   The count appears on the output the cycle after the last character
//   is accepted. Throughput, set by the window compare across the cell
//   chain and count update, is one character per cycle unless stalled.
// Reset:
//   Clears the window valid bits, the counter and the output valid flag;
//   pattern is zero, length 3, overlapping mode.
// Stalls:
//   A finished count waits in the output register. While it waits and
//   out_ready_i is low, in_ready_o is low and no character is accepted;
//   a count taken in a cycle frees the register for that same cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kmer_occurrence_counter
  import kocnt_pkg::*;
#(
  parameter int unsigned MAX_KMER_LEN = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Character input channel.
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SymW-1:0]     symbol_i,
  input  wire logic                last_symbol_i,
  // Count output channel.
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [CountW-1:0]   match_count_o
);

  localparam logic [LenW-1:0]   MaxLen   = LenW'(MAX_KMER_LEN);
  localparam logic [CountW-1:0] CountMax = '1;

  // Configuration registers.
  logic [PatW-1:0] pattern_q;
  logic [LenW-1:0] len_q;
  logic            overlap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LenW'(3);
      overlap_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PATTERN_CHARS:  pattern_q <= cfg_wdata_i[PatW-1:0];
        REG_PATTERN_LENGTH: len_q     <= cfg_wdata_i[LenW-1:0];
        REG_OVERLAP_MODE:   overlap_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Length as used by the compare, limited to the chain length.
  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] len_m1;
  assign len_eff = (len_q > MaxLen) ? MaxLen : len_q;
  assign len_m1  = len_eff - LenW'(1);

  // Handshake: a new character is taken unless a count is stuck in the
  // output register.
  logic       out_valid_q;
  logic       in_fire;
  cell_ctrl_t ctrl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ctrl.step  = in_fire;
  assign ctrl.flush = last_symbol_i;

  // Window chain: the newest character enters cell zero and ages by one
  // cell per accepted transaction.
  logic [SymW-1:0]         sym_link [MAX_KMER_LEN+1];
  logic                    vld_link [MAX_KMER_LEN+1];
  logic [MAX_KMER_LEN-1:0] hit;

  assign sym_link[0] = symbol_i;
  assign vld_link[0] = 1'b1;

  for (genvar g = 0; g < MAX_KMER_LEN; g++) begin : g_cell
    kocnt_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .sym_i     (sym_link[g]),
      .vld_i     (vld_link[g]),
      .pattern_i (pattern_q),
      .len_i     (len_eff),
      .sym_o     (sym_link[g+1]),
      .vld_o     (vld_link[g+1]),
      .hit_o     (hit[g])
    );
  end

  logic match;
  assign match = (len_eff != '0) && (&hit);

  // Count and skip update for the incoming character.
  logic [CountW-1:0] cnt_q, cnt_d, cnt_upd;
  logic [SkipW-1:0]  skip_q, skip_d, skip_upd;

  always_comb begin
    cnt_upd  = cnt_q;
    skip_upd = skip_q;
    if (skip_q != '0) begin
      skip_upd = skip_q - SkipW'(1);
    end else if (match) begin
      if (cnt_q != CountMax) begin
        cnt_upd = cnt_q + CountW'(1);
      end
      if (!overlap_q) begin
        skip_upd = len_m1[SkipW-1:0];
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    skip_d = skip_q;
    if (in_fire) begin
      cnt_d  = last_symbol_i ? '0 : cnt_upd;
      skip_d = last_symbol_i ? '0 : skip_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      skip_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
    end
  end

  // Output register for the record count.
  logic              out_valid_d;
  logic [CountW-1:0] out_count_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && last_symbol_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_symbol_i) begin
      out_count_q <= cnt_upd;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = out_count_q;

  // Checks on the counter and skip logic.
  `KOC_ASSERT(a_skip_bound, skip_q <= SkipW'(MAX_KMER_LEN - 1), "skip exceeds window length")
  `KOC_ASSERT(a_overlap_no_skip, (overlap_q && skip_q == '0) |=> skip_q == '0, "skip armed in overlap mode")
  `KOC_ASSERT(a_last_gives_result, (in_fire && last_symbol_i) |=> out_valid_q, "record end lost its count")
  `KOC_ASSERT(a_count_monotonic, !(in_fire && last_symbol_i) |=> cnt_q >= $past(cnt_q), "count decreased inside a record")

endmodule

`default_nettype wire
